### rtl/core/cll_pkg.sv
// Shared types and constants for the cursor linked list engine.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package cll_pkg;

    // Fixed field widths of the transaction ports
    localparam int OPCODE_W   = 2;
    localparam int STATUS_W   = 3;
    localparam int TAG_PORT_W = 16;
    localparam int RATING_W   = 8;
    localparam int COUNT_W    = 6;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_APPEND   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FORWARD  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_BACKWARD = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_REMOVE   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_AT_END   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_AT_START = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_EXEC,
        S_READ,
        S_RESP
    } t_state;

    // Controller to datapath commands, one per phase
    typedef struct packed {
        logic load;
        logic lookup;
        logic exec;
        logic read;
        logic resp;
    } t_cmd;

endpackage

`default_nettype wire

### rtl/core/cursor_linked_list_engine_top.sv
// Top level of the cursor linked list engine.
// Depends on cll_pkg, cll_ctrl and cll_datapath.
`default_nettype none

// Doubly linked list of up to POOL_DEPTH entries with a cursor. A transaction
// is accepted on a rising edge with start high and busy low; busy then stays
// high until the result has been shown. After acceptance a transaction goes
// through these states in order: S_LOOKUP reads the cursor's links and the
// top of the free stack, S_EXEC updates the list (all single port memory
// writes that can share the state), S_READ finishes the old tail's
// successor link on an append while reading the new cursor entry, and S_RESP
// shows the result. The result is on the o_ ports for exactly one cycle with
// o_valid high and the receiver cannot stall it, so capture it on that edge.
// Opcodes: append at tail, cursor forward, cursor backward, remove entry under
// cursor. Status: done, at end, at start, list empty, pool full. When the
// cursor is on no entry, the cursor fields read zero. Tags keep their low
// TAG_BITS bits. No clearing pass after reset: the free stack tracks which of
// its entries were never written and hands those out by index.
module cursor_linked_list_engine_top #(
    parameter int POOL_DEPTH = 32,
    parameter int TAG_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [cll_pkg::OPCODE_W-1:0]      i_opcode,
    input  logic [cll_pkg::TAG_PORT_W-1:0]    i_title_tag,
    input  logic [cll_pkg::TAG_PORT_W-1:0]    i_artist_tag,
    input  logic [cll_pkg::RATING_W-1:0]      i_rating_one,
    input  logic [cll_pkg::RATING_W-1:0]      i_rating_two,
    input  logic [cll_pkg::RATING_W-1:0]      i_rating_three,
    output logic                              o_valid,
    output logic [cll_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_cursor_valid,
    output logic [cll_pkg::TAG_PORT_W-1:0]    o_cursor_title,
    output logic [cll_pkg::TAG_PORT_W-1:0]    o_cursor_artist,
    output logic [cll_pkg::RATING_W-1:0]      o_cursor_rating_one,
    output logic [cll_pkg::RATING_W-1:0]      o_cursor_rating_two,
    output logic [cll_pkg::RATING_W-1:0]      o_cursor_rating_three,
    output logic [cll_pkg::COUNT_W-1:0]       o_entry_count
);
    import cll_pkg::*;

    t_cmd cmd;

    // sequencing
    cll_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // list storage and pointer update
    cll_datapath #(
        .POOL_DEPTH (POOL_DEPTH),
        .TAG_BITS   (TAG_BITS)
    ) u_datapath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .i_opcode              (i_opcode),
        .i_title_tag           (i_title_tag),
        .i_artist_tag          (i_artist_tag),
        .i_rating_one          (i_rating_one),
        .i_rating_two          (i_rating_two),
        .i_rating_three        (i_rating_three),
        .o_valid               (o_valid),
        .o_status              (o_status),
        .o_cursor_valid        (o_cursor_valid),
        .o_cursor_title        (o_cursor_title),
        .o_cursor_artist       (o_cursor_artist),
        .o_cursor_rating_one   (o_cursor_rating_one),
        .o_cursor_rating_two   (o_cursor_rating_two),
        .o_cursor_rating_three (o_cursor_rating_three),
        .o_entry_count         (o_entry_count)
    );

endmodule

`default_nettype wire

### rtl/core/cll_ctrl.sv
// Sequencing state machine of the cursor linked list engine.
// Depends on cll_pkg (t_state, t_cmd).
`default_nettype none

module cll_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output cll_pkg::t_cmd o_cmd
);
    import cll_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_RESP;
            end
            S_RESP: begin
                o_cmd.resp = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/cll_datapath.sv
// Slot pool, link memories, free stack and list pointers of the engine.
// Depends on cll_pkg; driven by commands from cll_ctrl.
`default_nettype none

module cll_datapath #(
    parameter int POOL_DEPTH = 32,
    parameter int TAG_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cll_pkg::t_cmd                     i_cmd,
    input  logic [cll_pkg::OPCODE_W-1:0]      i_opcode,
    input  logic [cll_pkg::TAG_PORT_W-1:0]    i_title_tag,
    input  logic [cll_pkg::TAG_PORT_W-1:0]    i_artist_tag,
    input  logic [cll_pkg::RATING_W-1:0]      i_rating_one,
    input  logic [cll_pkg::RATING_W-1:0]      i_rating_two,
    input  logic [cll_pkg::RATING_W-1:0]      i_rating_three,
    output logic                              o_valid,
    output logic [cll_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_cursor_valid,
    output logic [cll_pkg::TAG_PORT_W-1:0]    o_cursor_title,
    output logic [cll_pkg::TAG_PORT_W-1:0]    o_cursor_artist,
    output logic [cll_pkg::RATING_W-1:0]      o_cursor_rating_one,
    output logic [cll_pkg::RATING_W-1:0]      o_cursor_rating_two,
    output logic [cll_pkg::RATING_W-1:0]      o_cursor_rating_three,
    output logic [cll_pkg::COUNT_W-1:0]       o_entry_count
);
    import cll_pkg::*;

    localparam int AW    = $clog2(POOL_DEPTH);
    localparam int LW    = $clog2(POOL_DEPTH + 1);
    localparam int TAG_W = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;
    localparam int RAT_W = 3 * RATING_W;
    localparam logic [LW-1:0] NULL_SLOT = LW'(POOL_DEPTH);
    localparam logic [LW-1:0] FULL_TOP  = LW'(POOL_DEPTH);

    function automatic logic f_is_slot(input logic [LW-1:0] s);
        return s < NULL_SLOT;
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [LW-1:0] s);
        return f_is_slot(s) ? s[AW-1:0] : '0;
    endfunction

    // memories
    logic [LW-1:0]    m_succ   [POOL_DEPTH];
    logic [LW-1:0]    m_pred   [POOL_DEPTH];
    logic [TAG_W-1:0] m_title  [POOL_DEPTH];
    logic [TAG_W-1:0] m_artist [POOL_DEPTH];
    logic [RAT_W-1:0] m_rat    [POOL_DEPTH];
    logic [AW-1:0]    m_free   [POOL_DEPTH];

    // control state
    logic [LW-1:0] r_head, n_head;
    logic [LW-1:0] r_tail, n_tail;
    logic [LW-1:0] r_cursor, n_cursor;
    logic [LW-1:0] r_count, n_count;
    logic [LW-1:0] r_free_top, n_free_top;
    logic [LW-1:0] r_low, n_low;          // free stack entries below this hold their index
    logic          r_link_pend, n_link_pend;

    // payload
    logic [OPCODE_W-1:0] r_op;
    logic [TAG_W-1:0]    r_title;
    logic [TAG_W-1:0]    r_artist;
    logic [RAT_W-1:0]    r_rat;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [AW-1:0]       r_link_addr, n_link_addr;
    logic [LW-1:0]       r_link_val, n_link_val;
    logic [LW-1:0]       r_succ_rd;
    logic [LW-1:0]       r_pred_rd;
    logic [AW-1:0]       r_free_rd;
    logic                r_pop_fresh;
    logic [TAG_W-1:0]    r_rd_title;
    logic [TAG_W-1:0]    r_rd_artist;
    logic [RAT_W-1:0]    r_rd_rat;
    logic                r_cur_valid;

    // write ports
    logic          succ_we, pred_we, data_we, free_we;
    logic [AW-1:0] succ_wa, pred_wa, data_wa, free_wa;
    logic [LW-1:0] succ_wd, pred_wd;
    logic [AW-1:0] free_wd;

    logic [LW-1:0] pop_idx;
    logic [AW-1:0] pop_slot;
    logic [LW-1:0] pop_link;
    logic [LW-1:0] new_head;

    assign pop_idx  = r_free_top - LW'(1);
    assign pop_slot = r_pop_fresh ? pop_idx[AW-1:0] : r_free_rd;
    assign pop_link = LW'(pop_slot);

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_cursor    = r_cursor;
        n_count     = r_count;
        n_free_top  = r_free_top;
        n_low       = r_low;
        n_link_pend = r_link_pend;
        n_status    = r_status;
        n_link_addr = r_link_addr;
        n_link_val  = r_link_val;
        succ_we = 1'b0;  succ_wa = '0;  succ_wd = '0;
        pred_we = 1'b0;  pred_wa = '0;  pred_wd = '0;
        data_we = 1'b0;  data_wa = '0;
        free_we = 1'b0;  free_wa = '0;  free_wd = '0;
        new_head = r_head;

        if (i_cmd.exec) begin
            n_status = ST_DONE;
            case (r_op)
                OP_APPEND: begin
                    if (r_free_top == '0) begin
                        n_status = ST_FULL;
                    end else begin
                        data_we    = 1'b1;
                        data_wa    = pop_slot;
                        succ_we    = 1'b1;
                        succ_wa    = pop_slot;
                        succ_wd    = NULL_SLOT;
                        pred_we    = 1'b1;
                        pred_wa    = pop_slot;
                        n_free_top = pop_idx;
                        n_count    = r_count + LW'(1);
                        if (r_pop_fresh) begin
                            n_low = pop_idx;
                        end
                        if (!f_is_slot(r_head)) begin
                            pred_wd  = NULL_SLOT;
                            n_head   = pop_link;
                            n_tail   = pop_link;
                            n_cursor = pop_link;
                        end else begin
                            pred_wd = r_tail;
                            n_tail  = pop_link;
                            // old tail's successor goes in the next cycle
                            n_link_pend = f_is_slot(r_tail);
                            n_link_addr = f_addr(r_tail);
                            n_link_val  = pop_link;
                        end
                    end
                end
                OP_FORWARD: begin
                    if (!f_is_slot(r_cursor)) begin
                        n_status = ST_EMPTY;
                    end else if (!f_is_slot(r_succ_rd)) begin
                        n_status = ST_AT_END;
                    end else begin
                        n_cursor = r_succ_rd;
                    end
                end
                OP_BACKWARD: begin
                    if (!f_is_slot(r_cursor)) begin
                        n_status = ST_EMPTY;
                    end else if (!f_is_slot(r_pred_rd)) begin
                        n_status = ST_AT_START;
                    end else begin
                        n_cursor = r_pred_rd;
                    end
                end
                OP_REMOVE: begin
                    if (!f_is_slot(r_cursor)) begin
                        n_status = ST_EMPTY;
                    end else begin
                        if (f_is_slot(r_pred_rd)) begin
                            succ_we = 1'b1;
                            succ_wa = f_addr(r_pred_rd);
                            succ_wd = r_succ_rd;
                        end else begin
                            new_head = r_succ_rd;
                        end
                        n_head = new_head;
                        if (f_is_slot(r_succ_rd)) begin
                            pred_we  = 1'b1;
                            pred_wa  = f_addr(r_succ_rd);
                            pred_wd  = r_pred_rd;
                            n_cursor = r_succ_rd;
                        end else begin
                            n_tail   = r_pred_rd;
                            n_cursor = new_head;
                        end
                        if (r_free_top < FULL_TOP) begin
                            free_we    = 1'b1;
                            free_wa    = r_free_top[AW-1:0];
                            free_wd    = f_addr(r_cursor);
                            n_free_top = r_free_top + LW'(1);
                        end
                        if (r_count != '0) begin
                            n_count = r_count - LW'(1);
                        end
                    end
                end
                default: begin
                    n_status = r_status;
                end
            endcase
        end

        if (i_cmd.read && r_link_pend) begin
            succ_we     = 1'b1;
            succ_wa     = r_link_addr;
            succ_wd     = r_link_val;
            n_link_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= NULL_SLOT;
            r_tail      <= NULL_SLOT;
            r_cursor    <= NULL_SLOT;
            r_count     <= '0;
            r_free_top  <= FULL_TOP;
            r_low       <= FULL_TOP;
            r_link_pend <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_cursor    <= n_cursor;
            r_count     <= n_count;
            r_free_top  <= n_free_top;
            r_low       <= n_low;
            r_link_pend <= n_link_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_link_addr <= n_link_addr;
        r_link_val  <= n_link_val;
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_title  <= i_title_tag[TAG_W-1:0];
            r_artist <= i_artist_tag[TAG_W-1:0];
            r_rat    <= {i_rating_three, i_rating_two, i_rating_one};
        end
        if (i_cmd.lookup) begin
            r_pop_fresh <= pop_idx < r_low;
        end
        if (i_cmd.read) begin
            r_cur_valid <= f_is_slot(r_cursor);
        end
    end

    // link memories
    always_ff @(posedge i_clk) begin
        if (succ_we) begin
            m_succ[succ_wa] <= succ_wd;
        end
        if (i_cmd.lookup) begin
            r_succ_rd <= m_succ[f_addr(r_cursor)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pred_we) begin
            m_pred[pred_wa] <= pred_wd;
        end
        if (i_cmd.lookup) begin
            r_pred_rd <= m_pred[f_addr(r_cursor)];
        end
    end

    // free stack
    always_ff @(posedge i_clk) begin
        if (free_we) begin
            m_free[free_wa] <= free_wd;
        end
        if (i_cmd.lookup) begin
            r_free_rd <= m_free[pop_idx[AW-1:0]];
        end
    end

    // entry data
    always_ff @(posedge i_clk) begin
        if (data_we) begin
            m_title[data_wa]  <= r_title;
            m_artist[data_wa] <= r_artist;
            m_rat[data_wa]    <= r_rat;
        end
        if (i_cmd.read) begin
            r_rd_title  <= m_title[f_addr(r_cursor)];
            r_rd_artist <= m_artist[f_addr(r_cursor)];
            r_rd_rat    <= m_rat[f_addr(r_cursor)];
        end
    end

    assign o_valid               = i_cmd.resp;
    assign o_status              = r_status;
    assign o_cursor_valid        = r_cur_valid;
    assign o_cursor_title        = r_cur_valid ? TAG_PORT_W'(r_rd_title) : '0;
    assign o_cursor_artist       = r_cur_valid ? TAG_PORT_W'(r_rd_artist) : '0;
    assign o_cursor_rating_one   = r_cur_valid ? r_rd_rat[RATING_W-1:0] : '0;
    assign o_cursor_rating_two   = r_cur_valid ? r_rd_rat[2*RATING_W-1:RATING_W] : '0;
    assign o_cursor_rating_three = r_cur_valid ? r_rd_rat[3*RATING_W-1:2*RATING_W] : '0;
    assign o_entry_count         = COUNT_W'(r_count);

endmodule

`default_nettype wire

### rtl/core/cll_checker.sv
// Port-level checks for cursor_linked_list_engine_top, bound to every instance.
// Depends on cll_pkg (status codes).
`default_nettype none

module cll_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           o_valid,
    input logic [cll_pkg::STATUS_W-1:0]   o_status,
    input logic                           o_cursor_valid,
    input logic [cll_pkg::COUNT_W-1:0]    o_entry_count
);
    import cll_pkg::*;

    // an accepted transaction keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after an accepted transaction");

    // the block is free again right after showing a result
    a_result_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("busy still high after a result");

    // no cursor means the list is empty
    a_null_cursor_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_cursor_valid) |-> (o_entry_count == '0))
        else $error("cursor null with entries in the list");

    // an empty-list refusal never shows a cursor
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_EMPTY)) |-> !o_cursor_valid)
        else $error("list empty reported with a valid cursor");

    // a full pool means the cursor sits on an entry
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> o_cursor_valid)
        else $error("pool full reported without a cursor");

endmodule

bind cursor_linked_list_engine_top cll_checker u_cll_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_status       (o_status),
    .o_cursor_valid (o_cursor_valid),
    .o_entry_count  (o_entry_count)
);

`default_nettype wire

### sim/cursor_linked_list_engine_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for cursor_linked_list_engine_top: directed table, then random phases.
// Depends on cll_pkg and the engine RTL; keeps its own copy of the list to predict each result.

module cursor_linked_list_engine_top_tb;

    import cll_pkg::*;

    localparam int POOL        = 32;
    localparam int STALL_LIMIT = 256;
    localparam int RANDOM_N    = 400;
    localparam logic [5:0] NIL = 6'(POOL);

    // One transaction toward the engine
    typedef struct packed {
        logic [OPCODE_W-1:0]   op;
        logic [TAG_PORT_W-1:0] title;
        logic [TAG_PORT_W-1:0] artist;
        logic [RATING_W-1:0]   r1;
        logic [RATING_W-1:0]   r2;
        logic [RATING_W-1:0]   r3;
    } t_list_cmd;

    // One result: status plus what sits under the cursor
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic                  cv;
        logic [TAG_PORT_W-1:0] title;
        logic [TAG_PORT_W-1:0] artist;
        logic [RATING_W-1:0]   r1;
        logic [RATING_W-1:0]   r2;
        logic [RATING_W-1:0]   r3;
        logic [COUNT_W-1:0]    count;
    } t_cursor_view;

    // Directed row: the view is typed in only where chk is set
    typedef struct {
        t_list_cmd    c;
        bit           chk;
        t_cursor_view v;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [OPCODE_W-1:0]   i_opcode = '0;
    logic [TAG_PORT_W-1:0] i_title_tag = '0;
    logic [TAG_PORT_W-1:0] i_artist_tag = '0;
    logic [RATING_W-1:0]   i_rating_one = '0;
    logic [RATING_W-1:0]   i_rating_two = '0;
    logic [RATING_W-1:0]   i_rating_three = '0;
    logic                  o_valid;
    logic [STATUS_W-1:0]   o_status;
    logic                  o_cursor_valid;
    logic [TAG_PORT_W-1:0] o_cursor_title;
    logic [TAG_PORT_W-1:0] o_cursor_artist;
    logic [RATING_W-1:0]   o_cursor_rating_one;
    logic [RATING_W-1:0]   o_cursor_rating_two;
    logic [RATING_W-1:0]   o_cursor_rating_three;
    logic [COUNT_W-1:0]    o_entry_count;

    // Typed expectation travels with the transaction, driven like a port
    bit           row_chk = 1'b0;
    t_cursor_view row_view = '0;

    t_cursor_view cursor_views_due[$];
    int           mismatches = 0;
    int           views_seen = 0;
    int           sent_items = 0;
    int           stall_cycles = 0;
    bit           no_gaps = 1'b0;

    // Predicted list: links, entry data, free stack, ends and cursor
    logic [5:0]            succ_of[POOL];
    logic [5:0]            pred_of[POOL];
    logic [TAG_PORT_W-1:0] entry_title[POOL];
    logic [TAG_PORT_W-1:0] entry_artist[POOL];
    logic [RATING_W-1:0]   entry_r1[POOL];
    logic [RATING_W-1:0]   entry_r2[POOL];
    logic [RATING_W-1:0]   entry_r3[POOL];
    logic [4:0]            free_slots[POOL];
    int                    free_cnt;
    logic [5:0]            list_head;
    logic [5:0]            list_tail;
    logic [5:0]            cursor_at;
    int                    entries;

    cursor_linked_list_engine_top #(
        .POOL_DEPTH (POOL),
        .TAG_BITS   (16)
    ) u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_opcode              (i_opcode),
        .i_title_tag           (i_title_tag),
        .i_artist_tag          (i_artist_tag),
        .i_rating_one          (i_rating_one),
        .i_rating_two          (i_rating_two),
        .i_rating_three        (i_rating_three),
        .o_valid               (o_valid),
        .o_status              (o_status),
        .o_cursor_valid        (o_cursor_valid),
        .o_cursor_title        (o_cursor_title),
        .o_cursor_artist       (o_cursor_artist),
        .o_cursor_rating_one   (o_cursor_rating_one),
        .o_cursor_rating_two   (o_cursor_rating_two),
        .o_cursor_rating_three (o_cursor_rating_three),
        .o_entry_count         (o_entry_count)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_list_cmd pack_cmd(logic [OPCODE_W-1:0] op, logic [15:0] t,
                                           logic [15:0] a, logic [7:0] r1, logic [7:0] r2,
                                           logic [7:0] r3);
        t_list_cmd c;
        c = '{op: op, title: t, artist: a, r1: r1, r2: r2, r3: r3};
        return c;
    endfunction

    function automatic t_cursor_view list_view(logic [STATUS_W-1:0] st, logic cv,
                                               logic [15:0] t, logic [15:0] a, logic [7:0] r1,
                                               logic [7:0] r2, logic [7:0] r3,
                                               logic [5:0] cnt);
        t_cursor_view v;
        v = '{status: st, cv: cv, title: t, artist: a, r1: r1, r2: r2, r3: r3, count: cnt};
        return v;
    endfunction

    // Applies one transaction to the predicted list and returns the view it leaves
    function automatic t_cursor_view step_playlist(t_list_cmd c);
        t_cursor_view v;
        logic [5:0]   s;
        logic [5:0]   p;
        logic [5:0]   n;
        v = '0;
        v.status = ST_DONE;
        case (c.op)
            OP_APPEND: begin
                if (free_cnt == 0) begin
                    v.status = ST_FULL;
                end else begin
                    free_cnt--;
                    s = {1'b0, free_slots[free_cnt]};
                    entry_title[s]  = c.title;
                    entry_artist[s] = c.artist;
                    entry_r1[s]     = c.r1;
                    entry_r2[s]     = c.r2;
                    entry_r3[s]     = c.r3;
                    succ_of[s]      = NIL;
                    if (list_head == NIL) begin
                        pred_of[s] = NIL;
                        list_head  = s;
                        list_tail  = s;
                        cursor_at  = s;
                    end else begin
                        succ_of[list_tail] = s;
                        pred_of[s]         = list_tail;
                        list_tail          = s;
                    end
                    entries++;
                end
            end
            OP_FORWARD: begin
                if (cursor_at == NIL)               v.status = ST_EMPTY;
                else if (succ_of[cursor_at] == NIL) v.status = ST_AT_END;
                else                                cursor_at = succ_of[cursor_at];
            end
            OP_BACKWARD: begin
                if (cursor_at == NIL)               v.status = ST_EMPTY;
                else if (pred_of[cursor_at] == NIL) v.status = ST_AT_START;
                else                                cursor_at = pred_of[cursor_at];
            end
            OP_REMOVE: begin
                if (cursor_at == NIL) begin
                    v.status = ST_EMPTY;
                end else begin
                    s = cursor_at;
                    p = pred_of[s];
                    n = succ_of[s];
                    if (p != NIL) succ_of[p] = n;
                    else          list_head  = n;
                    if (n != NIL) pred_of[n] = p;
                    else          list_tail  = p;
                    // successor if there is one, else wrap to the head
                    cursor_at = (n != NIL) ? n : list_head;
                    free_slots[free_cnt] = s[4:0];
                    free_cnt++;
                    entries--;
                end
            end
            default: begin
                v.status = ST_DONE;
            end
        endcase
        if (cursor_at != NIL) begin
            v.cv     = 1'b1;
            v.title  = entry_title[cursor_at];
            v.artist = entry_artist[cursor_at];
            v.r1     = entry_r1[cursor_at];
            v.r2     = entry_r2[cursor_at];
            v.r3     = entry_r3[cursor_at];
        end
        v.count = entries[5:0];
        return v;
    endfunction

    // Random transaction; weights in percent, remove takes what is left
    function automatic t_list_cmd rand_cmd(int w_app, int w_fwd, int w_bwd);
        t_list_cmd c;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < w_app)                      c.op = OP_APPEND;
        else if (pick < w_app + w_fwd)         c.op = OP_FORWARD;
        else if (pick < w_app + w_fwd + w_bwd) c.op = OP_BACKWARD;
        else                                   c.op = OP_REMOVE;
        c.title  = ($urandom_range(0, 7) == 0) ? {16{$urandom_range(0, 1) == 1}} : 16'($urandom);
        c.artist = ($urandom_range(0, 7) == 0) ? {16{$urandom_range(0, 1) == 1}} : 16'($urandom);
        c.r1     = 8'($urandom);
        c.r2     = 8'($urandom);
        c.r3     = 8'($urandom);
        return c;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_view(t_cursor_view got, t_cursor_view want);
        if (got.status !== want.status)
            report_mismatch($sformatf("view %0d status %0h, want %0h", views_seen,
                                      got.status, want.status));
        if (got.cv !== want.cv)
            report_mismatch($sformatf("view %0d cursor_valid %0h, want %0h", views_seen,
                                      got.cv, want.cv));
        if (got.title !== want.title)
            report_mismatch($sformatf("view %0d title %0h, want %0h", views_seen,
                                      got.title, want.title));
        if (got.artist !== want.artist)
            report_mismatch($sformatf("view %0d artist %0h, want %0h", views_seen,
                                      got.artist, want.artist));
        if (got.r1 !== want.r1)
            report_mismatch($sformatf("view %0d rating_one %0h, want %0h", views_seen,
                                      got.r1, want.r1));
        if (got.r2 !== want.r2)
            report_mismatch($sformatf("view %0d rating_two %0h, want %0h", views_seen,
                                      got.r2, want.r2));
        if (got.r3 !== want.r3)
            report_mismatch($sformatf("view %0d rating_three %0h, want %0h", views_seen,
                                      got.r3, want.r3));
        if (got.count !== want.count)
            report_mismatch($sformatf("view %0d entry_count %0d, want %0d", views_seen,
                                      got.count, want.count));
    endtask

    // Drives one transaction at a rising edge and returns on the edge that accepts it.
    // start stays high into the next call when that one draws no gap.
    task automatic issue(t_list_cmd c, bit chk, t_cursor_view want);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_opcode       <= c.op;
        i_title_tag    <= c.title;
        i_artist_tag   <= c.artist;
        i_rating_one   <= c.r1;
        i_rating_two   <= c.r2;
        i_rating_three <= c.r3;
        row_chk        <= chk;
        row_view       <= want;
        do @(posedge i_clk); while (busy);
        sent_items++;
    endtask

    // Lowers start and waits until every predicted view has come back
    task automatic wait_list_quiet();
        start <= 1'b0;
        do @(negedge i_clk); while (cursor_views_due.size() != 0 || busy);
        @(posedge i_clk);
    endtask

    // Monitor: result strobe first, then the transaction accepted on this edge.
    // Everything is sampled pre-edge, so the order against driver updates does not matter.
    always @(posedge i_clk) begin
        t_cursor_view got;
        t_cursor_view want;
        if (i_rst_n) begin
            if (o_valid) begin
                got = '{status: o_status, cv: o_cursor_valid, title: o_cursor_title,
                        artist: o_cursor_artist, r1: o_cursor_rating_one,
                        r2: o_cursor_rating_two, r3: o_cursor_rating_three,
                        count: o_entry_count};
                if (cursor_views_due.size() == 0) begin
                    report_mismatch($sformatf("result with no transaction pending, status %0h",
                                              o_status));
                end else begin
                    want = cursor_views_due.pop_front();
                    check_view(got, want);
                end
                views_seen++;
            end
            if (start && !busy) begin
                // predictor runs on every transaction to keep its list in step
                want = step_playlist(pack_cmd(i_opcode, i_title_tag, i_artist_tag,
                                              i_rating_one, i_rating_two, i_rating_three));
                cursor_views_due.push_back(row_chk ? row_view : want);
            end
        end
    end

    // Watchdog: cycles with neither a transaction nor a result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[%0t] no progress for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_dir_row  dir_table[$];
        t_list_cmd c;
        int        n;
        int        k;

        for (k = 0; k < POOL; k++) begin
            free_slots[k]   = 5'(k);
            succ_of[k]      = '0;
            pred_of[k]      = '0;
            entry_title[k]  = '0;
            entry_artist[k] = '0;
            entry_r1[k]     = '0;
            entry_r2[k]     = '0;
            entry_r3[k]     = '0;
        end
        free_cnt  = POOL;
        list_head = NIL;
        list_tail = NIL;
        cursor_at = NIL;
        entries   = 0;

        // Empty list on every cursor op; data ports carry ones to show they are ignored
        dir_table.push_back('{pack_cmd(OP_FORWARD, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF),
                              1'b1, list_view(ST_EMPTY, 1'b0, 0, 0, 0, 0, 0, 0)});
        dir_table.push_back('{pack_cmd(OP_BACKWARD, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF),
                              1'b1, list_view(ST_EMPTY, 1'b0, 0, 0, 0, 0, 0, 0)});
        dir_table.push_back('{pack_cmd(OP_REMOVE, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF),
                              1'b1, list_view(ST_EMPTY, 1'b0, 0, 0, 0, 0, 0, 0)});
        // First entry takes the cursor; single entry is both head and tail
        dir_table.push_back('{pack_cmd(OP_APPEND, 16'hFFFF, 16'h0000, 8'hFF, 8'h00, 8'hFF),
                              1'b1, list_view(ST_DONE, 1'b1, 16'hFFFF, 16'h0000,
                                              8'hFF, 8'h00, 8'hFF, 1)});
        dir_table.push_back('{pack_cmd(OP_FORWARD, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0),
                              1'b1, list_view(ST_AT_END, 1'b1, 16'hFFFF, 16'h0000,
                                              8'hFF, 8'h00, 8'hFF, 1)});
        dir_table.push_back('{pack_cmd(OP_BACKWARD, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0),
                              1'b1, list_view(ST_AT_START, 1'b1, 16'hFFFF, 16'h0000,
                                              8'hFF, 8'h00, 8'hFF, 1)});
        // Second append leaves the cursor where it was
        dir_table.push_back('{pack_cmd(OP_APPEND, 16'h0000, 16'hFFFF, 8'h00, 8'hFF, 8'h00),
                              1'b1, list_view(ST_DONE, 1'b1, 16'hFFFF, 16'h0000,
                                              8'hFF, 8'h00, 8'hFF, 2)});
        dir_table.push_back('{pack_cmd(OP_FORWARD, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0),
                              1'b1, list_view(ST_DONE, 1'b1, 16'h0000, 16'hFFFF,
                                              8'h00, 8'hFF, 8'h00, 2)});
        dir_table.push_back('{pack_cmd(OP_FORWARD, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0),
                              1'b1, list_view(ST_AT_END, 1'b1, 16'h0000, 16'hFFFF,
                                              8'h00, 8'hFF, 8'h00, 2)});
        dir_table.push_back('{pack_cmd(OP_BACKWARD, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0),
                              1'b1, list_view(ST_DONE, 1'b1, 16'hFFFF, 16'h0000,
                                              8'hFF, 8'h00, 8'hFF, 2)});
        // Remove head: cursor goes to the successor
        dir_table.push_back('{pack_cmd(OP_REMOVE, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0),
                              1'b1, list_view(ST_DONE, 1'b1, 16'h0000, 16'hFFFF,
                                              8'h00, 8'hFF, 8'h00, 1)});
        // Remove the only entry: list empty, cursor on nothing
        dir_table.push_back('{pack_cmd(OP_REMOVE, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0),
                              1'b1, list_view(ST_DONE, 1'b0, 0, 0, 0, 0, 0, 0)});
        // Three entries, the first two on recycled slots, walk to the tail, remove it
        dir_table.push_back('{pack_cmd(OP_APPEND, 16'h1234, 16'h5678, 8'h01, 8'h80, 8'h7F),
                              1'b1, list_view(ST_DONE, 1'b1, 16'h1234, 16'h5678,
                                              8'h01, 8'h80, 8'h7F, 1)});
        dir_table.push_back('{pack_cmd(OP_APPEND, 16'hA5A5, 16'h5A5A, 8'h33, 8'hCC, 8'h0F),
                              1'b0, '0});
        dir_table.push_back('{pack_cmd(OP_APPEND, 16'h8001, 16'h7FFE, 8'hFE, 8'h01, 8'h80),
                              1'b0, '0});
        dir_table.push_back('{pack_cmd(OP_FORWARD, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0), 1'b0, '0});
        dir_table.push_back('{pack_cmd(OP_FORWARD, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0), 1'b0, '0});
        // Tail removed: no successor, cursor wraps to the head
        dir_table.push_back('{pack_cmd(OP_REMOVE, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0),
                              1'b1, list_view(ST_DONE, 1'b1, 16'h1234, 16'h5678,
                                              8'h01, 8'h80, 8'h7F, 2)});
        dir_table.push_back('{pack_cmd(OP_BACKWARD, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0),
                              1'b1, list_view(ST_AT_START, 1'b1, 16'h1234, 16'h5678,
                                              8'h01, 8'h80, 8'h7F, 2)});
        dir_table.push_back('{pack_cmd(OP_FORWARD, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0), 1'b0, '0});
        dir_table.push_back('{pack_cmd(OP_REMOVE, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0), 1'b0, '0});
        dir_table.push_back('{pack_cmd(OP_REMOVE, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0),
                              1'b1, list_view(ST_DONE, 1'b0, 0, 0, 0, 0, 0, 0)});

        // Synchronous reset
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[k])
            issue(dir_table[k].c, dir_table[k].chk, dir_table[k].v);

        // Random phases: fill past full, mixed traffic, drain past empty
        while (sent_items < dir_table.size() + RANDOM_N) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0: begin
                    wait_list_quiet();
                    n = POOL - entries + $urandom_range(1, 3);
                    repeat (n) issue(rand_cmd(100, 0, 0), 1'b0, '0);
                    n = $urandom_range(5, 20);
                    repeat (n) issue(rand_cmd(10, 45, 45), 1'b0, '0);
                end
                1: begin
                    n = $urandom_range(20, 40);
                    repeat (n) issue(rand_cmd(30, 25, 25), 1'b0, '0);
                end
                default: begin
                    wait_list_quiet();
                    n = entries + $urandom_range(1, 3);
                    repeat (n) begin
                        if ($urandom_range(0, 3) == 0)
                            issue(rand_cmd(0, 50, 50), 1'b0, '0);
                        issue(rand_cmd(0, 0, 0), 1'b0, '0);
                    end
                end
            endcase
        end

        wait_list_quiet();
        repeat (6) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
